// ===== src/pgd_pkg.sv =====
// Shared constants, register indexes and widths for the pixel to ground distance block.
package pgd_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int CFG_W   = 12;
  localparam int TILT_W  = 18;
  localparam int THR_W   = 16;
  localparam int DIST_W  = 24;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 18;
  localparam int SQ_W    = 2 * DIST_W + 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Default design parameters.
  localparam int DEF_PIXEL_BITS = 12;
  localparam int DEF_FRAC_BITS  = 16;

  // Register indexes on the configuration channel.
  localparam logic [IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTRE_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTRE_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIN_TILT = 3'd5;
  localparam logic [IDX_W-1:0] REG_COS_TILT = 3'd6;
  localparam logic [IDX_W-1:0] REG_DEN_THR  = 3'd7;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0]  RST_FOCAL_X  = 12'd500;
  localparam logic [CFG_W-1:0]  RST_FOCAL_Y  = 12'd520;
  localparam logic [CFG_W-1:0]  RST_CENTRE_X = 12'd400;
  localparam logic [CFG_W-1:0]  RST_CENTRE_Y = 12'd300;
  localparam logic [CFG_W-1:0]  RST_HEIGHT   = 12'd210;
  localparam logic [TILT_W-1:0] RST_SIN_TILT = 18'd61584;
  localparam logic [TILT_W-1:0] RST_COS_TILT = 18'd22415;
  localparam logic [THR_W-1:0]  RST_DEN_THR  = 16'd1;

endpackage

// ===== src/pixel_to_ground_distance.sv =====
// Top level: bounding box to ground distance, fully pipelined projection.
// Stages: coordinate divider stages, ground divider stages, 25 root and 9 register stages.
// Throughput: one word per cycle; the whole pipeline advances whenever the output register
// is empty or being taken, and every stage carries its own valid bit.
// Reset clears all valid bits and loads the register defaults; data registers are not reset.
module pixel_to_ground_distance
  import pgd_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // box_left_x, box_right_x, box_bottom_y, zero padding
  input  logic [((3*PIXEL_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // distance_mm_q4
  output logic [DIST_W-1:0]                      m_tdata,
  // no_ground_hit, saturated
  output logic [1:0]                             m_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [IDX_W-1:0]                       cfg_index,
  input  logic [DATA_W-1:0]                      cfg_data
);

  localparam int P   = PIXEL_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = (P > CFG_W) ? P : CFG_W;
  localparam int NA  = PW + F + 2;
  localparam int DA  = CFG_W + 1;
  localparam int YW  = NA + 1;
  localparam int PRW = YW + TILT_W;
  localparam int DW  = PRW + 1;
  localparam int AW  = DW - 15;
  localparam int MW  = 16 + ((AW > NA) ? AW : NA);
  localparam int NB  = MW + 1;
  localparam int R_W = SQ_W / 2;

  // Configuration registers.
  logic [CFG_W-1:0]         focal_x, focal_y, centre_x, centre_y, height;
  logic signed [TILT_W-1:0] sin_tilt, cos_tilt;
  logic [THR_W-1:0]         den_thr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= RST_FOCAL_X;
      focal_y  <= RST_FOCAL_Y;
      centre_x <= RST_CENTRE_X;
      centre_y <= RST_CENTRE_Y;
      height   <= RST_HEIGHT;
      sin_tilt <= RST_SIN_TILT;
      cos_tilt <= RST_COS_TILT;
      den_thr  <= RST_DEN_THR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOCAL_X:  focal_x  <= cfg_data[CFG_W-1:0];
        REG_FOCAL_Y:  focal_y  <= cfg_data[CFG_W-1:0];
        REG_CENTRE_X: centre_x <= cfg_data[CFG_W-1:0];
        REG_CENTRE_Y: centre_y <= cfg_data[CFG_W-1:0];
        REG_HEIGHT:   height   <= cfg_data[CFG_W-1:0];
        REG_SIN_TILT: sin_tilt <= cfg_data[TILT_W-1:0];
        REG_COS_TILT: cos_tilt <= cfg_data[TILT_W-1:0];
        REG_DEN_THR:  den_thr  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the output register is free or being emptied.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [CFG_W-1:0] fxe, fye;
  assign fxe = (focal_x == '0) ? CFG_W'(1) : focal_x;
  assign fye = (focal_y == '0) ? CFG_W'(1) : focal_y;

  // Stage 0: pixel offsets from the principal point and rounded division numerators.
  logic [P-1:0]    box_l, box_r, box_b;
  logic [PW+1:0]   sum_lr, c2, mag_x;
  logic [PW-1:0]   mag_y;
  logic            neg_y;

  assign box_l = s_tdata[P-1:0];
  assign box_r = s_tdata[2*P-1:P];
  assign box_b = s_tdata[3*P-1:2*P];

  always_comb begin
    sum_lr = (PW+2)'(box_l) + (PW+2)'(box_r);
    c2     = (PW+2)'(centre_x) << 1;
    mag_x  = (sum_lr >= c2) ? (sum_lr - c2) : (c2 - sum_lr);
    neg_y  = (PW'(box_b) < PW'(centre_y));
    mag_y  = neg_y ? (PW'(centre_y) - PW'(box_b)) : (PW'(box_b) - PW'(centre_y));
  end

  logic          v0;
  logic [NA-1:0] num_x0, num_y0;
  logic [DA-1:0] dvx0, dvy0;
  logic          neg0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x0 <= (NA'(mag_x) << F) + NA'(fxe);
      num_y0 <= (NA'(mag_y) << F) + NA'(fye >> 1);
      dvx0   <= DA'(fxe) << 1;
      dvy0   <= DA'(fye);
      neg0   <= neg_y;
    end
  end

  // Normalized coordinates.
  logic          v1;
  logic [NA-1:0] ax1, ym1;
  logic          neg1;

  pgd_div #(.NUM_W(NA), .DEN_W(DA), .PAY_W(1)) u_div_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .num(num_x0), .den(dvx0), .pay_in(neg0),
    .out_valid(), .quo(ax1), .pay_out()
  );

  pgd_div #(.NUM_W(NA), .DEN_W(DA), .PAY_W(1)) u_div_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .num(num_y0), .den(dvy0), .pay_in(neg0),
    .out_valid(v1), .quo(ym1), .pay_out(neg1)
  );

  // Stage 2: tilt products.
  logic signed [YW-1:0] yd1;
  assign yd1 = neg1 ? -$signed({1'b0, ym1}) : $signed({1'b0, ym1});

  logic                  v2;
  logic signed [PRW-1:0] sy2, cy2;
  logic [NA-1:0]         ax2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sy2 <= PRW'(sin_tilt) * PRW'(yd1);
      cy2 <= PRW'(cos_tilt) * PRW'(yd1);
      ax2 <= ax1;
    end
  end

  // Stage 3: rotated ray, denominator and vertical numerator.
  logic                 v3;
  logic signed [DW-1:0] den3, ny3;
  logic [NA-1:0]        ax3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3 <= DW'(sy2) + (DW'(cos_tilt) <<< F);
      ny3  <= DW'(cy2) - (DW'(sin_tilt) <<< F);
      ax3  <= ax2;
    end
  end

  // Stage 4: magnitudes rounded back to the fraction width, and the no-hit test.
  logic [DW-1:0] aden, any_m;
  logic [AW-1:0] ad_c, ay_c;

  always_comb begin
    aden  = den3[DW-1] ? DW'(-den3) : DW'(den3);
    any_m = ny3[DW-1]  ? DW'(-ny3)  : DW'(ny3);
    ad_c  = AW'(((DW+1)'(aden)  + (DW+1)'(16'h8000)) >> 16);
    ay_c  = AW'(((DW+1)'(any_m) + (DW+1)'(16'h8000)) >> 16);
  end

  logic          v4, nohit4;
  logic [AW-1:0] ad4, ay4;
  logic [NA-1:0] ax4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nohit4 <= (aden < (DW'(den_thr) << F)) || (ad_c == '0);
      ad4    <= ad_c;
      ay4    <= ay_c;
      ax4    <= ax3;
    end
  end

  // Stage 5: height scaling with the rounding offset for the ground divisions.
  logic [15:0] h16;
  assign h16 = {height, 4'b0000};

  logic          v5, nohit5;
  logic [NB-1:0] num_gx5, num_gy5;
  logic [AW-1:0] ad5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_gx5 <= NB'(MW'(h16) * MW'(ax4)) + NB'(ad4 >> 1);
      num_gy5 <= NB'(MW'(h16) * MW'(ay4)) + NB'(ad4 >> 1);
      ad5     <= ad4;
      nohit5  <= nohit4;
    end
  end

  // Ground plane coordinates.
  logic          v6, nohit6;
  logic [NB-1:0] gx6, gy6;

  pgd_div #(.NUM_W(NB), .DEN_W(AW), .PAY_W(1)) u_div_gx (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5), .num(num_gx5), .den(ad5), .pay_in(nohit5),
    .out_valid(), .quo(gx6), .pay_out()
  );

  pgd_div #(.NUM_W(NB), .DEN_W(AW), .PAY_W(1)) u_div_gy (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5), .num(num_gy5), .den(ad5), .pay_in(nohit5),
    .out_valid(v6), .quo(gy6), .pay_out(nohit6)
  );

  // Stage 7: range check of the coordinates.
  logic              v7, nohit7, sat7;
  logic [DIST_W-1:0] gx7, gy7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat7   <= (gx6 > NB'(DIST_MAX)) || (gy6 > NB'(DIST_MAX));
      gx7    <= gx6[DIST_W-1:0];
      gy7    <= gy6[DIST_W-1:0];
      nohit7 <= nohit6;
    end
  end

  // Stage 8: squares.
  logic                v8, nohit8, sat8;
  logic [2*DIST_W-1:0] xx8, yy8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx8    <= (2*DIST_W)'(gx7) * (2*DIST_W)'(gx7);
      yy8    <= (2*DIST_W)'(gy7) * (2*DIST_W)'(gy7);
      sat8   <= sat7;
      nohit8 <= nohit7;
    end
  end

  // Stage 9: sum of squares.
  logic            v9;
  logic [1:0]      flags9;
  logic [SQ_W-1:0] sum9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum9   <= SQ_W'(xx8) + SQ_W'(yy8);
      flags9 <= {sat8, nohit8};
    end
  end

  // Distance root.
  logic           v10;
  logic [1:0]     flags10;
  logic [R_W-1:0] root10;
  logic [R_W+1:0] rem10;

  pgd_isqrt #(.PAY_W(2)) u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v9), .radicand(sum9), .pay_in(flags9),
    .out_valid(v10), .root(root10), .remainder(rem10), .pay_out(flags10)
  );

  // Output register: round the root, then apply no-hit and saturation.
  logic [R_W:0] dist_r;
  assign dist_r = (R_W+1)'(root10) + (R_W+1)'(rem10 > (R_W+2)'(root10));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flags10[0]) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else if (flags10[1] || (dist_r > (R_W+1)'(DIST_MAX))) begin
        m_tdata <= DIST_MAX;
        m_tuser <= 2'b10;
      end else begin
        m_tdata <= dist_r[DIST_W-1:0];
        m_tuser <= 2'b00;
      end
    end
  end

`ifndef SYNTHESIS
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("no-hit word carries a distance");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == DIST_MAX))
    else $error("saturated word is not clamped");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v0) && $stable(v9))
    else $error("pipeline moved during a stall");
`endif

endmodule

// ===== src/pgd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module pgd_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [PAY_W-1:0] pay_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [PAY_W-1:0] pay_out
);

  // Per stage: partial remainder, numerator bits shifting out while quotient bits shift in.
  logic             vld [0:NUM_W];
  logic [DEN_W-1:0] rem [0:NUM_W];
  logic [NUM_W-1:0] nq  [0:NUM_W];
  logic [DEN_W-1:0] dv  [0:NUM_W];
  logic [PAY_W-1:0] pay [0:NUM_W];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dv[0]  = den;
  assign pay[0] = pay_in;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    // One compare and subtract per stage.
    always_comb begin
      trial    = {rem[k], nq[k][NUM_W-1]};
      diff     = trial - {1'b0, dv[k]};
      ge       = (trial >= {1'b0, dv[k]});
      rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= rem_next;
        nq[k+1]  <= {nq[k][NUM_W-2:0], ge};
        dv[k+1]  <= dv[k];
        pay[k+1] <= pay[k];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo       = nq[NUM_W];
  assign pay_out   = pay[NUM_W];

endmodule

// ===== src/pgd_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side payload.
module pgd_isqrt
  import pgd_pkg::*;
#(
  parameter int PAY_W = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [SQ_W-1:0]     radicand,
  input  logic [PAY_W-1:0]    pay_in,
  output logic                out_valid,
  output logic [SQ_W/2-1:0]   root,
  output logic [SQ_W/2+1:0]   remainder,
  output logic [PAY_W-1:0]    pay_out
);

  localparam int R_W = SQ_W / 2;

  logic             vld [0:R_W];
  logic [R_W+1:0]   rem [0:R_W];
  logic [R_W-1:0]   rt  [0:R_W];
  logic [SQ_W-1:0]  rad [0:R_W];
  logic [PAY_W-1:0] pay [0:R_W];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rad[0] = radicand;
  assign pay[0] = pay_in;

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [R_W+3:0] t;
    logic [R_W+3:0] trial;
    logic           ge;
    logic [R_W+3:0] diff;

    // Bring in two radicand bits and try the next root bit.
    always_comb begin
      t     = {rem[k], rad[k][SQ_W-1 -: 2]};
      trial = (R_W+4)'({rt[k], 2'b01});
      ge    = (t >= trial);
      diff  = t - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[R_W+1:0] : t[R_W+1:0];
        rt[k+1]  <= {rt[k][R_W-2:0], ge};
        rad[k+1] <= {rad[k][SQ_W-3:0], 2'b00};
        pay[k+1] <= pay[k];
      end
    end
  end

  assign out_valid = vld[R_W];
  assign root      = rt[R_W];
  assign remainder = rem[R_W];
  assign pay_out   = pay[R_W];

endmodule
